// ----- sv/lzsstd_pkg.sv -----
// Package for the LZSS token decoder: widths, parameter defaults and result status codes.
// No dependencies. Imported by every module of the decoder.
package lzsstd_pkg;

    localparam int DIST_W_DEF = 12;
    localparam int RUN_W_DEF  = 4;
    localparam int BYTE_W     = 8;
    localparam int TOTAL_W    = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIST  = 2'd1,
        ST_OVERRUN   = 2'd2
    } t_status;

endpackage

// ----- sv/lzsstd_hist.sv -----
// History ring memory for the LZSS token decoder: one write port, one registered read port.
// Depends on lzsstd_pkg for the byte width.
module lzsstd_hist #(
    parameter int ADDR_BITS = lzsstd_pkg::DIST_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [ADDR_BITS-1:0]           i_wr_addr,
    input  logic [lzsstd_pkg::BYTE_W-1:0]  i_wr_data,
    input  logic                           i_rd_en,
    input  logic [ADDR_BITS-1:0]           i_rd_addr,
    output logic [lzsstd_pkg::BYTE_W-1:0]  o_rd_data
);
    import lzsstd_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/lzss_token_decoder_unit.sv -----
// Top level of the LZSS token decoder: token sequencer, shared add/compare unit, output register.
// Depends on lzsstd_pkg and lzsstd_hist.
//
// Decodes separated LZSS tokens into a byte stream. A literal token gives one byte; a
// back reference gives copy_length bytes read one per cycle from the history ring, the
// last flagged with o_last. A zero-length reference gives nothing. A reference with
// distance zero or beyond the bytes produced so far, or any token that would take the
// output past total_length, gives a single result with status set and data zero, and
// changes no state. The two range checks run one after the other through one shared
// adder/comparator, and the copy runs at one byte per cycle, while the output is not
// stalled, through the single read port of the history memory. o_stall is high for the
// whole time a token is being worked on. total_length is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must write it only while the unit is idle, as the unit itself
// does not enforce this.
module lzss_token_decoder_unit #(
    parameter int DIST_W = lzsstd_pkg::DIST_W_DEF,
    parameter int RUN_W  = lzsstd_pkg::RUN_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_wr_en,
    input  logic [lzsstd_pkg::TOTAL_W-1:0]   i_cfg_wr_data,

    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_kind,
    input  logic [lzsstd_pkg::BYTE_W-1:0]    i_literal_byte,
    input  logic [DIST_W-1:0]                i_distance,
    input  logic [RUN_W-1:0]                 i_copy_length,

    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [lzsstd_pkg::BYTE_W-1:0]    o_data_byte,
    output logic                             o_last,
    output logic [lzsstd_pkg::STATUS_W-1:0]  o_status
);
    import lzsstd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_DIST,
        S_CHK_LEN,
        S_ERR,
        S_LIT,
        S_COPY
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_kind, n_kind;
    logic [BYTE_W-1:0]      r_lit, n_lit;
    logic [DIST_W-1:0]      r_dist, n_dist;
    logic [RUN_W-1:0]       r_cnt, n_cnt;
    logic                   r_first, n_first;
    logic [BYTE_W-1:0]      r_byte, n_byte;
    logic [DIST_W-1:0]      r_wp, n_wp;
    logic [TOTAL_W-1:0]     r_produced, n_produced;
    logic [TOTAL_W-1:0]     r_total, n_total;
    t_status                r_err, n_err;
    logic                   r_o_valid, n_o_valid;
    logic [BYTE_W-1:0]      r_o_data, n_o_data;
    logic                   r_o_last, n_o_last;
    t_status                r_o_status, n_o_status;

    logic [TOTAL_W-1:0]     cmp_a;
    logic [TOTAL_W-1:0]     cmp_add;
    logic [TOTAL_W-1:0]     cmp_b;
    logic [TOTAL_W:0]       cmp_sum;
    logic                   cmp_gt;

    logic                   out_free;
    logic                   accept;
    logic                   mem_wr_en;
    logic [BYTE_W-1:0]      mem_wr_data;
    logic                   mem_rd_en;
    logic [DIST_W-1:0]      mem_rd_addr;
    logic [BYTE_W-1:0]      mem_rd_data;
    logic [BYTE_W-1:0]      copy_byte;

    lzsstd_hist #(
        .ADDR_BITS (DIST_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // shared add/compare: distance > produced, then produced + length > total
    always_comb begin
        if (r_state == S_CHK_DIST) begin
            cmp_a   = TOTAL_W'(r_dist);
            cmp_add = '0;
            cmp_b   = r_produced;
        end else begin
            cmp_a   = r_produced;
            cmp_add = r_kind ? TOTAL_W'(r_cnt) : TOTAL_W'(1);
            cmp_b   = r_total;
        end
        cmp_sum = {1'b0, cmp_a} + {1'b0, cmp_add};
        cmp_gt  = cmp_sum > {1'b0, cmp_b};
    end

    assign out_free = !r_o_valid || !i_stall;
    assign accept   = i_valid && (r_state == S_IDLE);

    // distance one reads the slot written in the same cycle, so use the held byte
    assign copy_byte = (!r_first && r_dist == DIST_W'(1)) ? r_byte : mem_rd_data;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_lit      = r_lit;
        n_dist     = r_dist;
        n_cnt      = r_cnt;
        n_first    = r_first;
        n_byte     = r_byte;
        n_wp       = r_wp;
        n_produced = r_produced;
        n_total    = i_cfg_wr_en ? i_cfg_wr_data : r_total;
        n_err      = r_err;
        n_o_valid  = r_o_valid && i_stall;
        n_o_data   = r_o_data;
        n_o_last   = r_o_last;
        n_o_status = r_o_status;
        mem_wr_en   = 1'b0;
        mem_wr_data = r_lit;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_wp - r_dist;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind = i_kind;
                    n_lit  = i_literal_byte;
                    n_dist = i_distance;
                    n_cnt  = i_copy_length;
                    if (!(i_kind && i_copy_length == '0)) begin
                        n_state = S_CHK_DIST;
                    end
                end
            end
            S_CHK_DIST: begin
                if (r_kind && (r_dist == '0 || cmp_gt)) begin
                    n_err   = ST_BAD_DIST;
                    n_state = S_ERR;
                end else begin
                    n_state = S_CHK_LEN;
                end
            end
            S_CHK_LEN: begin
                if (cmp_gt) begin
                    n_err   = ST_OVERRUN;
                    n_state = S_ERR;
                end else if (!r_kind) begin
                    n_state = S_LIT;
                end else begin
                    mem_rd_en = 1'b1;
                    n_first   = 1'b1;
                    n_state   = S_COPY;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = '0;
                    n_o_last   = 1'b1;
                    n_o_status = r_err;
                    n_state    = S_IDLE;
                end
            end
            S_LIT: begin
                if (out_free) begin
                    mem_wr_en  = 1'b1;
                    n_wp       = r_wp + DIST_W'(1);
                    n_produced = r_produced + TOTAL_W'(1);
                    n_o_valid  = 1'b1;
                    n_o_data   = r_lit;
                    n_o_last   = 1'b1;
                    n_o_status = ST_OK;
                    n_state    = S_IDLE;
                end
            end
            S_COPY: begin
                if (out_free) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = copy_byte;
                    n_byte      = copy_byte;
                    n_first     = 1'b0;
                    n_wp        = r_wp + DIST_W'(1);
                    n_produced  = r_produced + TOTAL_W'(1);
                    n_cnt       = r_cnt - RUN_W'(1);
                    n_o_valid   = 1'b1;
                    n_o_data    = copy_byte;
                    n_o_last    = (r_cnt == RUN_W'(1));
                    n_o_status  = ST_OK;
                    if (r_cnt == RUN_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_wp + DIST_W'(1) - r_dist;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_lit      <= n_lit;
        r_dist     <= n_dist;
        r_cnt      <= n_cnt;
        r_first    <= n_first;
        r_byte     <= n_byte;
        r_err      <= n_err;
        r_o_data   <= n_o_data;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_produced <= '0;
            r_total    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_produced <= n_produced;
            r_total    <= n_total;
            r_o_valid  <= n_o_valid;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_data_byte = r_o_data;
    assign o_last      = r_o_last;
    assign o_status    = r_o_status;

`ifndef SYNTH
    a_wp_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp == r_produced[DIST_W-1:0])
        else $error("write pointer out of step with produced count");

    a_err_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_data_byte == '0)
        else $error("error result not a single zero byte");

    a_copy_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COPY |-> r_cnt != '0)
        else $error("copy running with zero bytes left");

    a_emit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY || r_state == S_LIT) && out_free
        |=> r_produced == $past(r_produced) + TOTAL_W'(1))
        else $error("emitted byte not counted");
`endif

endmodule

// ----- tb/sv/tb_lzss_token_decoder_unit.sv -----
// Testbench for lzss_token_decoder_unit: directed and random LZSS token streams checked
// byte by byte against a local decoder model. Depends on lzsstd_pkg and the decoder RTL.
module tb_lzss_token_decoder_unit;
    import lzsstd_pkg::*;

    localparam int RING_BITS   = DIST_W_DEF;
    localparam int LEN_BITS    = RUN_W_DEF;
    localparam int RING_DEPTH  = 1 << RING_BITS;
    localparam int SETTLE      = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_CYCLES  = 2_000_000;

    typedef enum logic {
        KIND_LITERAL = 1'b0,
        KIND_PAIR    = 1'b1
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind             kind;
        logic [BYTE_W-1:0]     lit;
        logic [RING_BITS-1:0]  back_dist;
        logic [LEN_BITS-1:0]   len;
    } t_token;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        t_status           status;
    } t_byte_result;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [TOTAL_W-1:0]    i_cfg_wr_data  = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic                  i_kind         = 1'b0;
    logic [BYTE_W-1:0]     i_literal_byte = '0;
    logic [RING_BITS-1:0]  i_distance     = '0;
    logic [LEN_BITS-1:0]   i_copy_length  = '0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [BYTE_W-1:0]     o_data_byte;
    logic                  o_last;
    logic [STATUS_W-1:0]   o_status;

    lzss_token_decoder_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_literal_byte (i_literal_byte),
        .i_distance     (i_distance),
        .i_copy_length  (i_copy_length),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    // decoder model state
    logic [BYTE_W-1:0]     ring_bytes [0:RING_DEPTH-1];
    logic [RING_BITS-1:0]  ring_wr    = '0;
    logic [TOTAL_W-1:0]    bytes_out  = '0;
    logic [TOTAL_W-1:0]    total_len  = '0;
    t_byte_result          expected_q [$];

    // stimulus planning: byte count as the stream will see it
    logic [TOTAL_W-1:0]    plan_count = '0;
    logic [TOTAL_W-1:0]    plan_total = '0;
    t_token                pending    [$];

    int unsigned mismatches   = 0;
    int unsigned tokens_in    = 0;
    int unsigned results_seen = 0;
    int unsigned error_bytes  = 0;
    int unsigned cfg_writes   = 0;
    int unsigned cycle_count  = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    bit          calm_in      = 1'b0;
    bit          calm_out     = 1'b0;
    bit          hold_done    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_idle(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic expect_byte(input logic [BYTE_W-1:0] data, input logic last,
                               input t_status status);
        expected_q.push_back({data, last, status});
        if (status != ST_OK) error_bytes++;
    endtask

    task automatic decode_token(input t_token t);
        logic [RING_BITS-1:0] rd_at;
        logic [BYTE_W-1:0]    b;
        if (t.kind == KIND_LITERAL) begin
            if (bytes_out >= total_len) begin
                expect_byte('0, 1'b1, ST_OVERRUN);
            end else begin
                ring_bytes[ring_wr] = t.lit;
                ring_wr++;
                bytes_out++;
                expect_byte(t.lit, 1'b1, ST_OK);
            end
        end else if (t.len == 0) begin
            // zero-length reference: no output, no state change
        end else if (t.back_dist == 0 || t.back_dist > bytes_out) begin
            expect_byte('0, 1'b1, ST_BAD_DIST);
        end else if ({1'b0, bytes_out} + t.len > {1'b0, total_len}) begin
            expect_byte('0, 1'b1, ST_OVERRUN);
        end else begin
            for (int i = 0; i < t.len; i++) begin
                rd_at = ring_wr - t.back_dist;
                b = ring_bytes[rd_at];
                ring_bytes[ring_wr] = b;
                ring_wr++;
                bytes_out++;
                expect_byte(b, (i + 1 == t.len), ST_OK);
            end
        end
    endtask

    task automatic push_tok(input t_tok_kind kind, input logic [BYTE_W-1:0] lit,
                            input logic [RING_BITS-1:0] back_dist,
                            input logic [LEN_BITS-1:0] len);
        if (kind == KIND_LITERAL) begin
            if (plan_count < plan_total) plan_count++;
        end else if (len != 0 && back_dist != 0 && back_dist <= plan_count
                     && {1'b0, plan_count} + len <= {1'b0, plan_total}) begin
            plan_count += len;
        end
        pending.push_back({kind, lit, back_dist, len});
    endtask

    // mostly valid references with random content, some literals, some noise
    task automatic queue_random(input int n);
        int unsigned r;
        int unsigned reach;
        logic [RING_BITS-1:0] d;
        logic [LEN_BITS-1:0]  l;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            reach = (plan_count > RING_DEPTH - 1) ? RING_DEPTH - 1 : plan_count;
            d = RING_BITS'($urandom_range(0, RING_DEPTH - 1));
            l = LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1));
            if (r < 18) begin
                push_tok(KIND_LITERAL, BYTE_W'($urandom_range(0, 255)), d, l);
            end else if (r < 90 && reach > 0) begin
                if ($urandom_range(0, 2) == 0)
                    d = RING_BITS'($urandom_range(1, reach));
                else
                    d = RING_BITS'($urandom_range(1, (reach < 16) ? reach : 16));
                if ($urandom_range(0, 3) != 0)
                    l = LEN_BITS'($urandom_range(12, 15));
                else
                    l = LEN_BITS'($urandom_range(1, 15));
                push_tok(KIND_PAIR, BYTE_W'($urandom_range(0, 255)), d, l);
            end else if (r < 94) begin
                push_tok(KIND_PAIR, BYTE_W'($urandom_range(0, 255)), '0, l);
            end else begin
                push_tok(KIND_PAIR, BYTE_W'($urandom_range(0, 255)), d, l);
            end
        end
    endtask

    // wait until the unit is idle with nothing outstanding
    task automatic drain();
        while (pending.size() != 0 || i_valid || expected_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] v);
        drain();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        total_len  = v;
        plan_total = v;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // token driver; the model advances on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                decode_token({t_tok_kind'(i_kind), i_literal_byte, i_distance, i_copy_length});
                tokens_in++;
                if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
                gap_left = pick_idle(calm_in);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending.size() != 0) begin : next_tok
                t_token t;
                t = pending.pop_front();
                i_kind         <= t.kind;
                i_literal_byte <= t.lit;
                i_distance     <= t.back_dist;
                i_copy_length  <= t.len;
                i_valid        <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back-pressure, including one long hold while tokens are queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
            if (!hold_done && pending.size() > 40) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = pick_idle(calm_out);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_mon
        t_byte_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result: data_byte %0h last %0b status %0d",
                       o_data_byte, o_last, o_status);
                mismatches++;
            end else begin
                e = expected_q.pop_front();
                if (o_data_byte !== e.data) begin
                    $error("data_byte: expected %0h, actual %0h", e.data, o_data_byte);
                    mismatches++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0b, actual %0b", e.last, o_last);
                    mismatches++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // total length still at reset value 0
        push_tok(KIND_LITERAL, 8'h3C, 12'd0, 4'd0);
        push_tok(KIND_PAIR, 8'h00, 12'd0, 4'd3);
        push_tok(KIND_PAIR, 8'h00, 12'd5, 4'd1);
        push_tok(KIND_PAIR, 8'h00, 12'd0, 4'd0);

        write_total(32'd40);
        push_tok(KIND_LITERAL, 8'h00, 12'd0, 4'd0);
        push_tok(KIND_LITERAL, 8'hFF, 12'd0, 4'd0);
        push_tok(KIND_LITERAL, 8'hA5, 12'd0, 4'd0);
        push_tok(KIND_LITERAL, 8'h5A, 12'd0, 4'd0);
        push_tok(KIND_PAIR, 8'h00, 12'd1, 4'd15);      // overlapping run
        push_tok(KIND_PAIR, 8'h00, 12'd4, 4'd4);
        push_tok(KIND_PAIR, 8'h00, 12'd0, 4'd2);
        push_tok(KIND_PAIR, 8'h00, 12'd24, 4'd1);      // one past produced
        push_tok(KIND_PAIR, 8'h00, 12'd23, 4'd1);      // reaches first byte
        push_tok(KIND_PAIR, 8'hFF, 12'd4095, 4'd0);
        push_tok(KIND_PAIR, 8'hFF, 12'd4095, 4'd15);
        push_tok(KIND_PAIR, 8'h00, 12'd3, 4'd15);
        push_tok(KIND_LITERAL, 8'h80, 12'd0, 4'd0);    // fills to total
        push_tok(KIND_LITERAL, 8'h11, 12'd0, 4'd0);
        push_tok(KIND_PAIR, 8'h00, 12'd1, 4'd1);
        push_tok(KIND_PAIR, 8'h00, 12'd0, 4'd1);       // distance wins over overrun

        write_total(32'd45);
        push_tok(KIND_PAIR, 8'h00, 12'd2, 4'd5);
        push_tok(KIND_LITERAL, 8'h77, 12'd0, 4'd0);

        write_total(32'hFFFF_FFFF);
        queue_random(100);
        drain();
        queue_random(100);

        write_total(plan_count + 32'd120);
        queue_random(100);

        write_total(32'hFFFF_FFFF);
        queue_random(150);

        drain();
        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            mismatches++;
        end
        $display("Decoded %0d tokens into %0d checked results (%0d error results), %0d bytes",
                 tokens_in, results_seen, error_bytes, bytes_out);
        $display("Total length written %0d times, run took %0d cycles", cfg_writes, cycle_count);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
